// ===== rtl/pthc_pkg.sv =====
// Package for the pre-cool then PID heater controller.
// Holds field widths, register indexes, reset values and shared types.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package pthc_pkg;

    localparam int TEMP_W     = 13;
    localparam int FRAME_W    = 16;
    localparam int TIME_W     = 32;
    localparam int GAIN_W     = 16;
    localparam int DRIVE_W    = 8;
    localparam int ERR_W      = TEMP_W + 1;
    localparam int DIFF_W     = ERR_W + 1;
    localparam int MCAND_W    = 24;
    localparam int PROD_W     = MCAND_W + GAIN_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int OPEN_BIT   = 2;
    localparam int TEMP_LSB   = 3;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KP        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KI        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KD        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW    = 3'd5;

    localparam logic [TEMP_W-1:0] TARGET_RST    = 13'd240;
    localparam logic [TEMP_W-1:0] THRESHOLD_RST = 13'd112;
    localparam logic [GAIN_W-1:0] KP_RST        = 16'd2330;
    localparam logic [GAIN_W-1:0] KI_RST        = 16'd77;
    localparam logic [GAIN_W-1:0] KD_RST        = 16'd461;
    localparam logic [TEMP_W-1:0] WINDOW_RST    = 13'd12;

    localparam logic [GAIN_W-1:0]  DERIV_SCALE = 16'd1000;
    localparam logic [DRIVE_W-1:0] DRIVE_FULL  = 8'hFF;
    localparam logic [DRIVE_W-1:0] DRIVE_ZERO  = 8'h00;

    typedef struct packed {
        logic [TEMP_W-1:0] target;
        logic [TEMP_W-1:0] threshold;
        logic [GAIN_W-1:0] kp;
        logic [GAIN_W-1:0] ki;
        logic [GAIN_W-1:0] kd;
        logic [TEMP_W-1:0] window;
    } cfg_regs_t;

    typedef struct packed {
        logic start;
    } unit_ctl_t;

    typedef struct packed {
        logic done;
    } unit_sts_t;

endpackage

`default_nettype wire

// ===== rtl/pthc_ifs.sv =====
// Channel interfaces for the heater controller: sample, result and configuration.
// Depends on pthc_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface pthc_in_if
    import pthc_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               restart;
    logic [FRAME_W-1:0] sensor_frame;
    logic [TIME_W-1:0]  time_ms;

    modport source (output valid, output restart, output sensor_frame, output time_ms,
                    input ready);
    modport sink (input valid, input restart, input sensor_frame, input time_ms,
                  output ready);
endinterface

interface pthc_out_if
    import pthc_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [DRIVE_W-1:0] heater_drive;
    logic [DRIVE_W-1:0] cooler_drive;
    logic [DRIVE_W-1:0] control_value;
    logic               cooling_mode;
    logic               probe_open;

    modport source (output valid, output heater_drive, output cooler_drive,
                    output control_value, output cooling_mode, output probe_open,
                    input ready);
    modport sink (input valid, input heater_drive, input cooler_drive,
                  input control_value, input cooling_mode, input probe_open,
                  output ready);
endinterface

interface pthc_cfg_if
    import pthc_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/pthc_cfg.sv =====
// Configuration register file of the heater controller.
// Depends on pthc_pkg and pthc_cfg_if.
`timescale 1ns / 1ps
`default_nettype none

module pthc_cfg
    import pthc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    pthc_cfg_if.sink   cfg,
    output cfg_regs_t  regs
);

    cfg_regs_t regs_reg;
    cfg_regs_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                REG_TARGET:    regs_next.target    = cfg.data[TEMP_W-1:0];
                REG_THRESHOLD: regs_next.threshold = cfg.data[TEMP_W-1:0];
                REG_KP:        regs_next.kp        = cfg.data[GAIN_W-1:0];
                REG_KI:        regs_next.ki        = cfg.data[GAIN_W-1:0];
                REG_KD:        regs_next.kd        = cfg.data[GAIN_W-1:0];
                REG_WINDOW:    regs_next.window    = cfg.data[TEMP_W-1:0];
                default:       regs_next           = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.target    <= TARGET_RST;
            regs_reg.threshold <= THRESHOLD_RST;
            regs_reg.kp        <= KP_RST;
            regs_reg.ki        <= KI_RST;
            regs_reg.kd        <= KD_RST;
            regs_reg.window    <= WINDOW_RST;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pthc_mul.sv =====
// Serial shift-add multiplier, one multiplier bit per cycle.
// Depends on pthc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pthc_mul
    import pthc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  unit_ctl_t          ctl,
    input  logic [MCAND_W-1:0] mcand,
    input  logic [GAIN_W-1:0]  mplier,
    output unit_sts_t          sts,
    output logic [PROD_W-1:0]  product
);

    localparam int CNT_W = $clog2(GAIN_W + 1);

    logic [PROD_W-1:0]  prod_reg;
    logic [PROD_W-1:0]  prod_next;
    logic [MCAND_W-1:0] mcand_reg;
    logic [MCAND_W-1:0] mcand_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic               done_reg;
    logic               done_next;
    logic [MCAND_W:0]   hi_sum;

    assign product  = prod_reg;
    assign sts.done = done_reg;

    always_comb
    begin
        hi_sum = {1'b0, prod_reg[PROD_W-1:GAIN_W]}
                 + (prod_reg[0] ? {1'b0, mcand_reg} : {(MCAND_W + 1){1'b0}});
        prod_next  = prod_reg;
        mcand_next = mcand_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        if (ctl.start)
        begin
            prod_next  = {{MCAND_W{1'b0}}, mplier};
            mcand_next = mcand;
            cnt_next   = CNT_W'(GAIN_W);
        end
        else if (cnt_reg != '0)
        begin
            prod_next = {hi_sum, prod_reg[GAIN_W-1:1]};
            cnt_next  = cnt_reg - CNT_W'(1);
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= prod_next;
        mcand_reg <= mcand_next;
    end

endmodule

`default_nettype wire

// ===== rtl/pthc_div.sv =====
// Serial restoring divider, one quotient bit per cycle.
// Depends on pthc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pthc_div
    import pthc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  unit_ctl_t         ctl,
    input  logic [PROD_W-1:0] dividend,
    input  logic [TIME_W-1:0] divisor,
    output unit_sts_t         sts,
    output logic [PROD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(PROD_W + 1);

    logic [TIME_W-1:0] rem_reg;
    logic [TIME_W-1:0] rem_next;
    logic [PROD_W-1:0] quo_reg;
    logic [PROD_W-1:0] quo_next;
    logic [TIME_W-1:0] dsr_reg;
    logic [TIME_W-1:0] dsr_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              done_reg;
    logic              done_next;
    logic [TIME_W:0]   trial;
    logic [TIME_W:0]   trial_sub;
    logic              fits;

    assign quotient = quo_reg;
    assign sts.done = done_reg;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[PROD_W-1]};
        trial_sub = trial - {1'b0, dsr_reg};
        fits      = (trial >= {1'b0, dsr_reg});
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (ctl.start)
        begin
            rem_next = '0;
            quo_next = dividend;
            dsr_next = divisor;
            cnt_next = CNT_W'(PROD_W);
        end
        else if (cnt_reg != '0)
        begin
            rem_next  = fits ? trial_sub[TIME_W-1:0] : trial[TIME_W-1:0];
            quo_next  = {quo_reg[PROD_W-2:0], fits};
            cnt_next  = cnt_reg - CNT_W'(1);
            done_next = (cnt_reg == CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

endmodule

`default_nettype wire

// ===== rtl/precool_then_pid_heater_control.sv =====
// Pre-cool then PID heater controller, top level with the tick sequencer.
// A cooling or open-probe tick goes from S_EVAL to S_DONE, which registers its result.
// A heating tick runs four serial multiplies and a serial divide, or skips the
// divide when no time has elapsed.
// One tick is processed at a time, so a new sample is taken only in S_IDLE.
// Reset is asynchronous; it resets the config registers and controller state only.
`timescale 1ns / 1ps
`default_nettype none

module precool_then_pid_heater_control
    import pthc_pkg::*;
#(
    parameter int GAIN_FRAC_BITS = 8,
    parameter int INTEGRAL_WIDTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    pthc_cfg_if.sink    cfg,
    pthc_in_if.sink     sample,
    pthc_out_if.source  result
);

    localparam int SW    = ((INTEGRAL_WIDTH > PROD_W + 1) ? INTEGRAL_WIDTH : PROD_W + 1) + 2;
    localparam int SHIFT = GAIN_FRAC_BITS + 2;

    localparam logic signed [SW-1:0] INT_MAX =
        {{(SW - INTEGRAL_WIDTH + 1){1'b0}}, {(INTEGRAL_WIDTH - 1){1'b1}}};
    localparam logic signed [SW-1:0] INT_MIN = ~INT_MAX;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_EVAL  = 4'd1;
    localparam logic [3:0] S_MUL_P = 4'd2;
    localparam logic [3:0] S_MUL_I = 4'd3;
    localparam logic [3:0] S_MUL_K = 4'd4;
    localparam logic [3:0] S_MUL_D = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_INTEG = 4'd7;
    localparam logic [3:0] S_SUM   = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    cfg_regs_t          regs;
    unit_ctl_t          mul_ctl;
    unit_sts_t          mul_sts;
    unit_ctl_t          div_ctl;
    unit_sts_t          div_sts;
    logic [MCAND_W-1:0] mul_mcand;
    logic [GAIN_W-1:0]  mul_mplier;
    logic [PROD_W-1:0]  mul_product;
    logic [PROD_W-1:0]  div_quotient;

    logic [3:0]                 state_reg, state_next;
    logic                       out_valid_reg, out_valid_next;
    logic                       in_cooling_reg, in_cooling_next;
    logic signed [INTEGRAL_WIDTH-1:0] integ_reg, integ_next;
    logic signed [ERR_W-1:0]    last_err_reg, last_err_next;
    logic [TIME_W-1:0]          last_time_reg, last_time_next;
    logic [DRIVE_W-1:0]         cooler_reg, cooler_next;
    logic [DRIVE_W-1:0]         last_ctrl_reg, last_ctrl_next;

    logic                       restart_reg, restart_next;
    logic [FRAME_W-1:0]         frame_reg, frame_next;
    logic [TIME_W-1:0]          time_reg, time_next;
    logic [TIME_W-1:0]          dt_reg, dt_next;
    logic signed [SW-1:0]       p_reg, p_next;
    logic signed [SW-1:0]       i_reg, i_next;
    logic signed [SW-1:0]       d_reg, d_next;
    logic signed [SW-1:0]       psd_reg, psd_next;
    logic [DRIVE_W-1:0]         heater_reg, heater_next;
    logic [DRIVE_W-1:0]         o_heater_reg, o_heater_next;
    logic [DRIVE_W-1:0]         o_cooler_reg, o_cooler_next;
    logic [DRIVE_W-1:0]         o_ctrl_reg, o_ctrl_next;
    logic                       o_cool_reg, o_cool_next;
    logic                       o_open_reg, o_open_next;

    logic [TEMP_W-1:0]          temp;
    logic                       probe_bit;
    logic signed [ERR_W-1:0]    err_calc;
    logic [ERR_W-1:0]           err_mag;
    logic signed [DIFF_W-1:0]   diff;
    logic [DIFF_W-1:0]          diff_mag;
    logic signed [SW-1:0]       integ_ext;
    logic signed [SW-1:0]       integ_sum;
    logic signed [SW-1:0]       total;
    logic [DRIVE_W-1:0]         ctrl;

    function automatic logic signed [SW-1:0] apply_sign(input logic neg,
                                                       input logic [PROD_W-1:0] mag);
        logic signed [SW-1:0] ext;
        begin
            ext        = $signed({{(SW - PROD_W){1'b0}}, mag});
            apply_sign = neg ? -ext : ext;
        end
    endfunction

    pthc_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    pthc_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (mul_ctl),
        .mcand   (mul_mcand),
        .mplier  (mul_mplier),
        .sts     (mul_sts),
        .product (mul_product)
    );

    pthc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (div_ctl),
        .dividend (mul_product),
        .divisor  (dt_reg),
        .sts      (div_sts),
        .quotient (div_quotient)
    );

    assign sample.ready         = (state_reg == S_IDLE);
    assign result.valid         = out_valid_reg;
    assign result.heater_drive  = o_heater_reg;
    assign result.cooler_drive  = o_cooler_reg;
    assign result.control_value = o_ctrl_reg;
    assign result.cooling_mode  = o_cool_reg;
    assign result.probe_open    = o_open_reg;

    always_comb
    begin
        temp      = frame_reg[FRAME_W-1:TEMP_LSB];
        probe_bit = frame_reg[OPEN_BIT];
        err_calc  = $signed({1'b0, regs.target}) - $signed({1'b0, temp});
        err_mag   = err_calc[ERR_W-1] ? ERR_W'(-err_calc) : ERR_W'(err_calc);
        diff      = $signed({err_calc[ERR_W-1], err_calc})
                    - $signed({last_err_reg[ERR_W-1], last_err_reg});
        diff_mag  = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
        integ_ext = SW'(integ_reg);
        integ_sum = integ_ext + i_reg;
        total     = psd_reg + integ_ext;
        if (total[SW-1])
        begin
            ctrl = DRIVE_ZERO;
        end
        else if (|total[SW-2:SHIFT+DRIVE_W])
        begin
            ctrl = DRIVE_FULL;
        end
        else
        begin
            ctrl = total[SHIFT+DRIVE_W-1:SHIFT];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        out_valid_next  = out_valid_reg;
        in_cooling_next = in_cooling_reg;
        integ_next      = integ_reg;
        last_err_next   = last_err_reg;
        last_time_next  = last_time_reg;
        cooler_next     = cooler_reg;
        last_ctrl_next  = last_ctrl_reg;
        restart_next    = restart_reg;
        frame_next      = frame_reg;
        time_next       = time_reg;
        dt_next         = dt_reg;
        p_next          = p_reg;
        i_next          = i_reg;
        d_next          = d_reg;
        psd_next        = psd_reg;
        heater_next     = heater_reg;
        o_heater_next   = o_heater_reg;
        o_cooler_next   = o_cooler_reg;
        o_ctrl_next     = o_ctrl_reg;
        o_cool_next     = o_cool_reg;
        o_open_next     = o_open_reg;
        mul_ctl.start   = 1'b0;
        div_ctl.start   = 1'b0;
        mul_mcand       = {{(MCAND_W - ERR_W){1'b0}}, err_mag};
        mul_mplier      = regs.kp;

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (sample.valid)
                begin
                    restart_next = sample.restart;
                    frame_next   = sample.sensor_frame;
                    time_next    = sample.time_ms;
                    state_next   = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (restart_reg)
                begin
                    in_cooling_next = 1'b1;
                end
                heater_next = DRIVE_ZERO;
                state_next  = S_DONE;
                if (!probe_bit)
                begin
                    if (in_cooling_reg || restart_reg)
                    begin
                        if (temp > regs.threshold)
                        begin
                            cooler_next = DRIVE_ZERO;
                        end
                        else
                        begin
                            cooler_next     = DRIVE_FULL;
                            in_cooling_next = 1'b0;
                        end
                    end
                    else
                    begin
                        dt_next       = time_reg - last_time_reg;
                        mul_ctl.start = 1'b1;
                        state_next    = S_MUL_P;
                    end
                end
            end
            S_MUL_P:
            begin
                if (mul_sts.done)
                begin
                    p_next        = apply_sign(err_calc[ERR_W-1], mul_product);
                    mul_mplier    = regs.ki;
                    mul_ctl.start = 1'b1;
                    state_next    = S_MUL_I;
                end
            end
            S_MUL_I:
            begin
                if (mul_sts.done)
                begin
                    i_next        = apply_sign(err_calc[ERR_W-1], mul_product);
                    mul_mcand     = {{(MCAND_W - DIFF_W){1'b0}}, diff_mag};
                    mul_mplier    = DERIV_SCALE;
                    mul_ctl.start = 1'b1;
                    state_next    = S_MUL_K;
                end
            end
            S_MUL_K:
            begin
                if (mul_sts.done)
                begin
                    mul_mcand     = mul_product[MCAND_W-1:0];
                    mul_mplier    = regs.kd;
                    mul_ctl.start = 1'b1;
                    state_next    = S_MUL_D;
                end
            end
            S_MUL_D:
            begin
                if (mul_sts.done)
                begin
                    if (dt_reg == '0)
                    begin
                        d_next     = '0;
                        state_next = S_INTEG;
                    end
                    else
                    begin
                        div_ctl.start = 1'b1;
                        state_next    = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                if (div_sts.done)
                begin
                    d_next     = apply_sign(diff[DIFF_W-1], div_quotient);
                    state_next = S_INTEG;
                end
            end
            S_INTEG:
            begin
                if (err_mag < {1'b0, regs.window})
                begin
                    if (integ_sum > INT_MAX)
                    begin
                        integ_next = INT_MAX[INTEGRAL_WIDTH-1:0];
                    end
                    else if (integ_sum < INT_MIN)
                    begin
                        integ_next = INT_MIN[INTEGRAL_WIDTH-1:0];
                    end
                    else
                    begin
                        integ_next = integ_sum[INTEGRAL_WIDTH-1:0];
                    end
                end
                psd_next   = p_reg + d_reg;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                last_ctrl_next = ctrl;
                heater_next    = DRIVE_FULL - ctrl;
                last_time_next = time_reg;
                last_err_next  = err_calc;
                state_next     = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    o_heater_next  = heater_reg;
                    o_cooler_next  = cooler_reg;
                    o_ctrl_next    = last_ctrl_reg;
                    o_cool_next    = in_cooling_reg;
                    o_open_next    = probe_bit;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            in_cooling_reg <= 1'b1;
            integ_reg      <= '0;
            last_err_reg   <= '0;
            last_time_reg  <= '0;
            cooler_reg     <= DRIVE_ZERO;
            last_ctrl_reg  <= DRIVE_ZERO;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            in_cooling_reg <= in_cooling_next;
            integ_reg      <= integ_next;
            last_err_reg   <= last_err_next;
            last_time_reg  <= last_time_next;
            cooler_reg     <= cooler_next;
            last_ctrl_reg  <= last_ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        restart_reg  <= restart_next;
        frame_reg    <= frame_next;
        time_reg     <= time_next;
        dt_reg       <= dt_next;
        p_reg        <= p_next;
        i_reg        <= i_next;
        d_reg        <= d_next;
        psd_reg      <= psd_next;
        heater_reg   <= heater_next;
        o_heater_reg <= o_heater_next;
        o_cooler_reg <= o_cooler_next;
        o_ctrl_reg   <= o_ctrl_next;
        o_cool_reg   <= o_cool_next;
        o_open_reg   <= o_open_next;
    end

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// Testbench for precool_then_pid_heater_control: runs the block's own channel
// interfaces, predicts every tick in a scoreboard class and checks each result.
// Depends on pthc_pkg, the channel interfaces in pthc_ifs.sv and the top level RTL.
`timescale 1ns / 1ps

module testbench
    import pthc_pkg::*;
;

    localparam int GAIN_FRAC  = 8;
    localparam int INTEG_BITS = 32;
    localparam longint INTEG_MAX = (longint'(1) <<< (INTEG_BITS - 1)) - 1;
    localparam longint INTEG_MIN = -INTEG_MAX - 1;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;
    localparam int TEMP_MAX = (1 << TEMP_W) - 1;

    typedef struct packed {
        logic [DRIVE_W-1:0] heater;
        logic [DRIVE_W-1:0] cooler;
        logic [DRIVE_W-1:0] control;
        logic               cooling;
        logic               open;
    } drive_t;

    class heater_model;
        cfg_regs_t  regs;
        bit         cooling;
        longint     err_sum;
        longint     prev_err;
        bit [31:0]  prev_time;
        bit [7:0]   cooler;
        bit [7:0]   control;
        drive_t     expected_drives[$];
        int         mismatches;

        function new();
            regs.target    = TARGET_RST;
            regs.threshold = THRESHOLD_RST;
            regs.kp        = KP_RST;
            regs.ki        = KI_RST;
            regs.kd        = KD_RST;
            regs.window    = WINDOW_RST;
            cooling        = 1'b1;
            err_sum        = 0;
            prev_err       = 0;
            prev_time      = '0;
            cooler         = DRIVE_ZERO;
            control        = DRIVE_ZERO;
            mismatches     = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_TARGET:    regs.target    = value[TEMP_W-1:0];
                REG_THRESHOLD: regs.threshold = value[TEMP_W-1:0];
                REG_KP:        regs.kp        = value[GAIN_W-1:0];
                REG_KI:        regs.ki        = value[GAIN_W-1:0];
                REG_KD:        regs.kd        = value[GAIN_W-1:0];
                REG_WINDOW:    regs.window    = value[TEMP_W-1:0];
                default:       ;
            endcase
        endfunction

        function void predict_tick(bit restart, logic [FRAME_W-1:0] frame,
                                   logic [TIME_W-1:0] stamp);
            bit        open;
            longint    temp;
            longint    err;
            longint    mag;
            longint    p_term;
            longint    d_term;
            longint    acc;
            longint    total;
            longint    whole;
            bit [31:0] dt;
            bit [7:0]  ctrl;
            bit [7:0]  heater;
            drive_t    want;
            open   = frame[OPEN_BIT];
            temp   = longint'(frame[FRAME_W-1:TEMP_LSB]);
            heater = DRIVE_ZERO;
            if (restart)
                cooling = 1'b1;
            if (!open)
            begin
                if (cooling)
                begin
                    if (temp > longint'(regs.threshold))
                        cooler = DRIVE_ZERO;
                    else
                    begin
                        cooler  = DRIVE_FULL;
                        cooling = 1'b0;
                    end
                end
                else
                begin
                    err    = longint'(regs.target) - temp;
                    mag    = (err < 0) ? -err : err;
                    p_term = longint'(regs.kp) * err;
                    d_term = 0;
                    dt     = stamp - prev_time;
                    if (mag < longint'(regs.window))
                    begin
                        acc = err_sum + longint'(regs.ki) * err;
                        if (acc > INTEG_MAX)
                            acc = INTEG_MAX;
                        if (acc < INTEG_MIN)
                            acc = INTEG_MIN;
                        err_sum = acc;
                    end
                    if (dt != 0)
                        d_term = (longint'(regs.kd) * (err - prev_err) * longint'(DERIV_SCALE))
                                 / longint'(dt);
                    total = p_term + err_sum + d_term;
                    if (total < 0)
                        ctrl = DRIVE_ZERO;
                    else
                    begin
                        whole = total >>> (GAIN_FRAC + 2);
                        ctrl  = (whole > 255) ? DRIVE_FULL : whole[7:0];
                    end
                    prev_time = stamp;
                    prev_err  = err;
                    control   = ctrl;
                    heater    = DRIVE_FULL - ctrl;
                end
            end
            want.heater  = heater;
            want.cooler  = cooler;
            want.control = control;
            want.cooling = cooling;
            want.open    = open;
            expected_drives.push_back(want);
        endfunction

        function void compare(string what, int want, int got);
            if (want != got)
            begin
                mismatches++;
                $display("%0t %s mismatch: expected %0d actual %0d", $time, what, want, got);
            end
        endfunction

        function void check_drive(drive_t got);
            drive_t want;
            if (expected_drives.size() == 0)
            begin
                mismatches++;
                $display("%0t result with no tick pending: expected none actual %h",
                         $time, got);
                return;
            end
            want = expected_drives.pop_front();
            compare("heater_drive", want.heater, got.heater);
            compare("cooler_drive", want.cooler, got.cooler);
            compare("control_value", want.control, got.control);
            compare("cooling_mode", want.cooling, got.cooling);
            compare("probe_open", want.open, got.open);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    bit          steady;
    bit          stall_request;
    logic [31:0] clock_ms;
    heater_model model = new();

    pthc_cfg_if cfg_ch ();
    pthc_in_if  sample_ch ();
    pthc_out_if result_ch ();

    precool_then_pid_heater_control #(
        .GAIN_FRAC_BITS (GAIN_FRAC),
        .INTEGRAL_WIDTH (INTEG_BITS)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .sample (sample_ch),
        .result (result_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_request)
            begin
                stall_request = 1'b0;
                result_ch.ready <= 1'b0;
                repeat (400) @(negedge clk);
            end
            result_ch.ready <= steady || ($urandom_range(99) >= 29);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
            model.check_drive({result_ch.heater_drive, result_ch.cooler_drive,
                               result_ch.control_value, result_ch.cooling_mode,
                               result_ch.probe_open});
    end

    function automatic logic [FRAME_W-1:0] frame_of(logic [TEMP_W-1:0] temp, bit open);
        logic [1:0] low_bits;
        low_bits = 2'($urandom_range(3));
        return {temp, open, low_bits};
    endfunction

    function automatic logic [CFG_DATA_W-1:0] with_junk(logic [TEMP_W-1:0] value);
        logic [CFG_DATA_W-TEMP_W-1:0] junk;
        junk = (CFG_DATA_W - TEMP_W)'($urandom);
        return {junk, value};
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        model.write_reg(idx, value);
        @(negedge clk);
    endtask

    task automatic send_tick(bit restart, logic [FRAME_W-1:0] frame, logic [TIME_W-1:0] stamp);
        while (!steady && $urandom_range(99) < 29)
        begin
            sample_ch.valid <= 1'b0;
            @(negedge clk);
        end
        sample_ch.valid        <= 1'b1;
        sample_ch.restart      <= restart;
        sample_ch.sensor_frame <= frame;
        sample_ch.time_ms      <= stamp;
        do @(posedge clk); while (!sample_ch.ready);
        model.predict_tick(restart, frame, stamp);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        sample_ch.valid <= 1'b0;
        while (model.expected_drives.size() != 0)
            @(negedge clk);
    endtask

    task automatic load_config(int phase);
        logic [CFG_DATA_W-1:0] v [6];
        case (phase)
            0: v = '{16'd8191, 16'd8191, 16'd65535, 16'd65535, 16'd65535, 16'd8191};
            1: v = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
            2: v = '{16'd8191, 16'd8191, 16'd0, 16'd65535, 16'd0, 16'd8191};
            3: v = '{16'd0, 16'd8191, 16'd0, 16'd65535, 16'd0, 16'd8191};
            default:
            begin
                v[0] = 16'($urandom_range(TEMP_MAX));
                v[1] = 16'($urandom_range(TEMP_MAX));
                v[2] = 16'(($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(4000));
                v[3] = 16'(($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(400));
                v[4] = 16'(($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(2000));
                v[5] = 16'(($urandom_range(3) == 0) ? $urandom_range(TEMP_MAX) : $urandom_range(64));
            end
        endcase
        write_reg(REG_TARGET, with_junk(v[0][TEMP_W-1:0]));
        write_reg(REG_THRESHOLD, with_junk(v[1][TEMP_W-1:0]));
        write_reg(REG_KP, v[2]);
        write_reg(REG_KI, v[3]);
        write_reg(REG_KD, v[4]);
        write_reg(REG_WINDOW, with_junk(v[5][TEMP_W-1:0]));
        write_reg(phase[0] ? REG_SPARE_A : REG_SPARE_B, 16'($urandom));
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic directed_ticks();
        send_tick(1'b0, frame_of(13'd8191, 1'b0), 32'd1000);
        send_tick(1'b0, frame_of(13'd0, 1'b1), 32'd1100);
        send_tick(1'b1, 16'hFFFF, 32'd1200);
        send_tick(1'b0, frame_of(13'd113, 1'b0), 32'd1300);
        send_tick(1'b0, frame_of(13'd112, 1'b0), 32'd1400);
        send_tick(1'b0, frame_of(13'd235, 1'b0), 32'd1500);
        send_tick(1'b0, frame_of(13'd236, 1'b0), 32'd1500);
        send_tick(1'b0, frame_of(13'd240, 1'b0), 32'd1501);
        send_tick(1'b0, frame_of(13'd0, 1'b0), 32'd1800);
        send_tick(1'b0, frame_of(13'd8191, 1'b0), 32'd2100);
        send_tick(1'b0, frame_of(13'd250, 1'b1), 32'd2400);
        send_tick(1'b0, frame_of(13'd245, 1'b0), 32'hFFFF_FFF0);
        send_tick(1'b0, frame_of(13'd238, 1'b0), 32'h0000_0010);
        send_tick(1'b1, frame_of(13'd200, 1'b0), 32'h0000_0020);
        send_tick(1'b1, frame_of(13'd50, 1'b0), 32'h0000_0030);
        send_tick(1'b0, frame_of(13'd0, 1'b0), 32'h0000_0040);
        send_tick(1'b0, frame_of(13'd239, 1'b0), 32'h8000_0000);
        send_tick(1'b0, frame_of(13'd241, 1'b0), 32'h8000_00FA);
        send_tick(1'b1, frame_of(13'd0, 1'b1), 32'h8000_01F4);
        send_tick(1'b0, frame_of(13'd0, 1'b0), 32'h8000_02EE);
        send_tick(1'b0, frame_of(13'd243, 1'b0), 32'h8000_0300);
        send_tick(1'b0, frame_of(13'd237, 1'b0), 32'h8000_0301);
        clock_ms = 32'h8000_0400;
    endtask

    task automatic random_ticks(int count, int pause_at);
        int t;
        int span;
        int r;
        bit restart;
        bit open;
        for (int i = 0; i < count; i++)
        begin
            if (i == pause_at)
                wait_idle();
            r    = $urandom_range(99);
            span = int'(model.regs.window) * 2 + 8;
            if (model.cooling && r < 50)
                t = int'($urandom_range(int'(model.regs.threshold)));
            else if (r < 80)
                t = int'($urandom_range(2 * span)) + int'(model.regs.target) - span;
            else
                t = int'($urandom_range(TEMP_MAX));
            if (t < 0)
                t = 0;
            if (t > TEMP_MAX)
                t = TEMP_MAX;
            restart = ($urandom_range(99) < 3);
            open    = ($urandom_range(99) < 5);
            r       = $urandom_range(99);
            if (r < 8)
                clock_ms = clock_ms;
            else if (r < 85)
                clock_ms = clock_ms + $urandom_range(600, 1);
            else if (r < 95)
                clock_ms = clock_ms + $urandom_range(200000, 601);
            else
                clock_ms = $urandom;
            send_tick(restart, frame_of(13'(t), open), clock_ms);
        end
    endtask

    initial
    begin
        rst_n                  = 1'b0;
        steady                 = 1'b0;
        stall_request          = 1'b0;
        clock_ms               = '0;
        cfg_ch.valid           = 1'b0;
        cfg_ch.index           = '0;
        cfg_ch.data            = '0;
        sample_ch.valid        = 1'b0;
        sample_ch.restart      = 1'b0;
        sample_ch.sensor_frame = '0;
        sample_ch.time_ms      = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        directed_ticks();
        for (int phase = 0; phase < 11; phase++)
        begin
            wait_idle();
            load_config(phase);
            steady = (phase == 5);
            if (phase == 4)
                stall_request = 1'b1;
            random_ticks(102, (phase == 7) ? 50 : -1);
        end
        steady = 1'b0;

        wait_idle();
        repeat (150) @(negedge clk);
        if (model.mismatches == 0 && model.expected_drives.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
